@@ rtl/free_list_slot_allocator_assert.svh @@
// Assertion macros for the free-list slot allocator.
`ifndef FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define FSLA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define FSLA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
    else $error(msg);

`endif

@@ rtl/fsla_pkg.sv @@
// Package: widths, codes and beat types for the free-list slot allocator.
`timescale 1ns / 1ps
package fsla_pkg;

  localparam int SLOT_W  = 6;
  localparam int COUNT_W = 7;
  localparam int DEPTH   = 64;

  localparam logic [COUNT_W-1:0] CAPACITY = COUNT_W'(DEPTH);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [1:0] ST_BAD_FREE  = 2'd2;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic MARK_BUSY = 1'b1;
  localparam logic MARK_FREE = 1'b0;

  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot_index;
  } fsla_req_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  granted_slot;
    logic [1:0]         status;
    logic [COUNT_W-1:0] in_use;
  } fsla_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // request beat taken, stack top read launched
    logic exec;    // apply request, register result
  } fsla_cmd_t;

endpackage

@@ rtl/fsla_ctrl.sv @@
// Controller state machine: sequences accept, execute and result strobe.
`timescale 1ns / 1ps
module fsla_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output fsla_pkg::fsla_cmd_t cmd
);
  import fsla_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd.accept = 1'b0;
    cmd.exec   = 1'b0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

endmodule

@@ rtl/fsla_datapath.sv @@
// Datapath: free stack memory, busy marks, counters and result register.
`timescale 1ns / 1ps
module fsla_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  fsla_pkg::fsla_cmd_t   cmd,
  input  fsla_pkg::fsla_req_t   req,
  input  logic                  cfg_we,
  input  logic [fsla_pkg::COUNT_W-1:0] cfg_data,
  output fsla_pkg::fsla_rsp_t   result
);
  import fsla_pkg::*;

  logic [SLOT_W-1:0] stack_mem [DEPTH];
  logic [SLOT_W-1:0] rd_data;
  logic [DEPTH-1:0]  entry_valid;   // clear: entry still holds its own index
  logic [DEPTH-1:0]  busy_marks;
  logic [COUNT_W-1:0] active_slots;
  logic [COUNT_W-1:0] stack_count;
  logic [COUNT_W-1:0] busy_total;

  logic              req_mode;
  logic [SLOT_W-1:0] req_slot;

  logic [COUNT_W-1:0] cfg_sat;
  logic [SLOT_W-1:0]  rd_addr;
  logic [SLOT_W-1:0]  pop_slot;
  logic [SLOT_W-1:0]  push_addr;
  logic               alloc_ok;
  logic               free_ok;
  logic [COUNT_W-1:0] busy_total_next;

  assign cfg_sat   = (cfg_data > CAPACITY) ? CAPACITY : cfg_data;
  // count is stable between accept and execute, so one address serves both
  assign rd_addr   = SLOT_W'(stack_count - COUNT_W'(1));
  assign push_addr = stack_count[SLOT_W-1:0];
  assign pop_slot  = entry_valid[rd_addr] ? rd_data : rd_addr;

  assign alloc_ok = (req_mode == MODE_ALLOC) && (stack_count != '0)
                    && (stack_count <= CAPACITY);
  assign free_ok  = (req_mode == MODE_FREE)
                    && ({1'b0, req_slot} < active_slots)
                    && (busy_marks[req_slot] == MARK_BUSY)
                    && (stack_count < CAPACITY);

  always_comb begin
    busy_total_next = busy_total;
    if (alloc_ok) begin
      busy_total_next = busy_total + COUNT_W'(1);
    end else if (free_ok && busy_total != '0) begin
      busy_total_next = busy_total - COUNT_W'(1);
    end
  end

  // stack memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rd_data <= stack_mem[rd_addr];
    end
    if (cmd.exec && free_ok) begin
      stack_mem[push_addr] <= req_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_mode <= req.mode;
      req_slot <= req.slot_index;
    end
    if (cmd.exec) begin
      result.granted_slot <= alloc_ok ? pop_slot : '0;
      result.status       <= alloc_ok ? ST_OK :
                             free_ok  ? ST_OK :
                             (req_mode == MODE_ALLOC) ? ST_EXHAUSTED : ST_BAD_FREE;
      result.in_use       <= busy_total_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_slots <= CAPACITY;
      stack_count  <= CAPACITY;
      busy_total   <= '0;
      entry_valid  <= '0;
      busy_marks   <= {DEPTH{MARK_FREE}};
    end else if (cfg_we) begin
      active_slots <= cfg_sat;
      stack_count  <= cfg_sat;
      busy_total   <= '0;
      entry_valid  <= '0;
      busy_marks   <= {DEPTH{MARK_FREE}};
    end else if (cmd.exec) begin
      busy_total <= busy_total_next;
      if (alloc_ok) begin
        stack_count          <= stack_count - COUNT_W'(1);
        busy_marks[pop_slot] <= MARK_BUSY;
      end else if (free_ok) begin
        stack_count            <= stack_count + COUNT_W'(1);
        entry_valid[push_addr] <= 1'b1;
        busy_marks[req_slot]   <= MARK_FREE;
      end
    end
  end

endmodule

@@ rtl/free_list_slot_allocator.sv @@
// Top level of the LIFO free-list slot allocator.
// The result strobe (done) is registered from the EXEC state that follows the accepting edge.
// A new request is not taken while the controller is in EXEC, where busy is high.
// A new request may be taken in the same cycle as the previous result strobe.
// Reset and every active_slots write rebuild the free list by clearing the per-entry valid bits (no clearing pass).
// The receiver cannot stall: each result is shown for exactly one cycle.
`timescale 1ns / 1ps
module free_list_slot_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  fsla_pkg::fsla_req_t           req,
  output logic                          done,
  output fsla_pkg::fsla_rsp_t           result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fsla_pkg::COUNT_W-1:0]  cfg_data
);
  import fsla_pkg::*;

  `include "free_list_slot_allocator_assert.svh"

  fsla_cmd_t cmd;

  // Register writes must arrive only while idle (user's duty, not enforced); the port is always open.
  assign cfg_ready = 1'b1;

  // Controller: IDLE takes the beat and launches the stack-top read,
  // EXEC applies the request, and the strobe follows in the cycle after it.
  fsla_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  // Datapath: stack memory with per-entry valid bits standing in for the
  // rebuilt contents, busy marks in flops, counts and the result register.
  fsla_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .req      (req),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .result   (result)
  );

  // accepted beat keeps the block busy for its execute cycle
  `FSLA_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  // every accepted beat gives a result strobe after its execute cycle
  `FSLA_ASSERT_NEXT(a_accept_done, start && !busy, ##1 done, "missing result strobe")
  // strobe only while the controller is back in idle
  `FSLA_ASSERT_IMPL(a_done_idle, done, !busy, "result strobe while busy")
  // failed requests hand out slot zero
  `FSLA_ASSERT_IMPL(a_fail_zero, done && result.status != ST_OK,
                    result.granted_slot == '0, "failed request granted a slot")
  // busy count never exceeds the pool
  `FSLA_ASSERT_IMPL(a_in_use_max, done, result.in_use <= CAPACITY, "in_use above capacity")

endmodule

@@ tb/sv/tb_free_list_slot_allocator.sv @@
// Self-checking testbench for the LIFO free-list slot allocator.
`timescale 1ns / 1ps
module tb_free_list_slot_allocator;
  import fsla_pkg::*;

  localparam int QUIET_LIMIT = 2000;   // cycles with no beat of any kind
  localparam int PHASES      = 12;
  localparam int PHASE_ITEMS = 137;

  // Shadow of the allocator: stack, busy marks and counters at block widths.
  typedef struct packed {
    logic [DEPTH-1:0][SLOT_W-1:0] stack;
    logic [DEPTH-1:0]             marks;
    logic [COUNT_W-1:0]           depth_n;   // entries on the free stack
    logic [COUNT_W-1:0]           held;      // busy slots
    logic [COUNT_W-1:0]           managed;   // active_slots after saturation
  } pool_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  fsla_req_t          req = '0;
  logic               done;
  fsla_rsp_t          result;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [COUNT_W-1:0] cfg_data = '0;

  pool_t      mdl_pool;      // advanced as requests are accepted
  pool_t      gen_pool;      // advanced as requests are queued, steers stimulus
  fsla_req_t  pending_req[$];
  fsla_rsp_t  expected_rsp[$];
  fsla_req_t  taken_req;
  fsla_rsp_t  pred_rsp;
  fsla_rsp_t  want_rsp;
  logic       next_start;
  int         idle_pct = 6;
  int         errs = 0;
  int         quiet = 0;

  free_list_slot_allocator i_dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #10 clk = ~clk;

  // Rebuild after reset or a write: slots managed-1 .. 0, highest on top.
  function automatic pool_t pool_reload(input pool_t p, input logic [COUNT_W-1:0] v);
    logic [COUNT_W-1:0] m;
    m = (v > CAPACITY) ? CAPACITY : v;
    for (int i = 0; i < DEPTH; i++) begin
      if (i < m) p.stack[i] = SLOT_W'(i);
    end
    p.depth_n = m;
    p.marks   = {DEPTH{MARK_FREE}};
    p.held    = '0;
    p.managed = m;
    return p;
  endfunction

  // One request against the shadow; returns the beat the block should answer.
  task automatic pool_serve(inout pool_t p, input fsla_req_t r, output fsla_rsp_t o);
    logic [SLOT_W-1:0] top;
    o = '0;
    o.status = ST_OK;
    if (r.mode == MODE_ALLOC) begin
      if (p.depth_n == 0 || p.depth_n > CAPACITY) begin
        o.status = ST_EXHAUSTED;
      end else begin
        p.depth_n = p.depth_n - 1'b1;
        top = p.stack[p.depth_n[SLOT_W-1:0]];
        p.marks[top] = MARK_BUSY;
        p.held = p.held + 1'b1;
        o.granted_slot = top;
      end
    end else begin
      if ({1'b0, r.slot_index} >= p.managed || p.marks[r.slot_index] != MARK_BUSY
          || p.depth_n >= CAPACITY) begin
        o.status = ST_BAD_FREE;
      end else begin
        p.marks[r.slot_index] = MARK_FREE;
        p.stack[p.depth_n[SLOT_W-1:0]] = r.slot_index;
        p.depth_n = p.depth_n + 1'b1;
        if (p.held > 0) p.held = p.held - 1'b1;
      end
    end
    o.in_use = p.held;
  endtask

  task automatic queue_req(input logic mode, input logic [SLOT_W-1:0] slot);
    fsla_req_t r;
    fsla_rsp_t dummy;
    r.mode = mode;
    r.slot_index = slot;
    pending_req.push_back(r);
    pool_serve(gen_pool, r, dummy);
  endtask

  // Register write, only once the block has drained every outstanding beat.
  task automatic write_slots(input logic [COUNT_W-1:0] v);
    while (pending_req.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    mdl_pool = pool_reload(mdl_pool, v);
    gen_pool = pool_reload(gen_pool, v);
  endtask

  // Mostly well-formed traffic: allocs and frees of slots known to be busy,
  // with a tenth of noise (random mode, random slot) for the error paths.
  task automatic queue_burst(input int n, input int alloc_pct);
    int nheld;
    int k;
    logic [SLOT_W-1:0] slot;
    for (int j = 0; j < n; j++) begin
      slot = SLOT_W'($urandom);
      nheld = 0;
      for (int i = 0; i < DEPTH; i++) begin
        if (gen_pool.marks[i] == MARK_BUSY) nheld++;
      end
      if ($urandom_range(99) < 10) begin
        queue_req(1'($urandom_range(1)), slot);
      end else if ($urandom_range(99) < alloc_pct || nheld == 0) begin
        queue_req(MODE_ALLOC, slot);
      end else begin
        k = $urandom_range(nheld - 1);
        for (int i = 0; i < DEPTH; i++) begin
          if (gen_pool.marks[i] == MARK_BUSY) begin
            if (k == 0) slot = SLOT_W'(i);
            k--;
          end
        end
        queue_req(MODE_FREE, slot);
      end
    end
  endtask

  // Request driver: the head of the queue is what sits on req while start is up.
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      next_start = start;
      if (start && !busy) begin
        taken_req = pending_req.pop_front();
        pool_serve(mdl_pool, taken_req, pred_rsp);
        expected_rsp.push_back(pred_rsp);
        next_start = 1'b0;
      end
      if (!next_start && pending_req.size() != 0 && $urandom_range(99) >= idle_pct) begin
        next_start = 1'b1;
        req <= pending_req[0];
      end
      start <= next_start;
    end
  end

  // Result monitor: each done beat against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_rsp.size() == 0) begin
        $error("result beat with nothing outstanding: %p", result);
        errs++;
      end else begin
        want_rsp = expected_rsp.pop_front();
        if (result.granted_slot !== want_rsp.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d", want_rsp.granted_slot,
                 result.granted_slot);
          errs++;
        end
        if (result.status !== want_rsp.status) begin
          $error("status: expected %0d, got %0d", want_rsp.status, result.status);
          errs++;
        end
        if (result.in_use !== want_rsp.in_use) begin
          $error("in_use: expected %0d, got %0d", want_rsp.in_use, result.in_use);
          errs++;
        end
      end
    end
  end

  // Watchdog: any request, result or register beat resets the count.
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= QUIET_LIMIT) begin
      $display("tb_free_list_slot_allocator: errors");
      $finish;
    end
  end

  initial begin
    int plan [PHASES];
    int left;
    int len;
    int pct;
    plan = '{1, 64, 0, 127, 2, 65, 5, -1, 16, 3, -1, 64};
    mdl_pool = pool_reload('0, COUNT_W'(64));
    gen_pool = mdl_pool;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Full pool after reset: LIFO order, double free, free of an idle slot.
    queue_req(MODE_ALLOC, 6'd63);
    queue_req(MODE_ALLOC, 6'd0);
    queue_req(MODE_ALLOC, 6'd21);
    queue_req(MODE_FREE, 6'd62);
    queue_req(MODE_FREE, 6'd62);
    queue_req(MODE_FREE, 6'd0);
    queue_req(MODE_ALLOC, 6'd42);
    queue_req(MODE_FREE, 6'd63);
    queue_req(MODE_FREE, 6'd61);
    queue_req(MODE_FREE, 6'd62);
    queue_req(MODE_FREE, 6'd63);
    // Single slot: exhaustion and frees beyond the managed range.
    write_slots(COUNT_W'(1));
    queue_req(MODE_ALLOC, 6'd0);
    queue_req(MODE_ALLOC, 6'd63);
    queue_req(MODE_FREE, 6'd1);
    queue_req(MODE_FREE, 6'd63);
    queue_req(MODE_FREE, 6'd0);
    queue_req(MODE_FREE, 6'd0);
    // No slot managed at all.
    write_slots(COUNT_W'(0));
    queue_req(MODE_ALLOC, 6'd0);
    queue_req(MODE_FREE, 6'd0);
    // Oversized write saturates to the full pool.
    write_slots(COUNT_W'(127));
    queue_req(MODE_ALLOC, 6'd0);
    queue_req(MODE_FREE, 6'd63);

    // Random phases: sender idles 6 %, then 72 %, then not at all.
    for (int ph = 0; ph < PHASES; ph++) begin
      write_slots(COUNT_W'(plan[ph] < 0 ? $urandom_range(1, 64) : plan[ph]));
      idle_pct = (ph < 4) ? 6 : (ph < 8) ? 72 : 0;
      left = PHASE_ITEMS;
      while (left > 0) begin
        len = $urandom_range(16, 80);
        if (len > left) len = left;
        case ($urandom_range(2))
          0: pct = 15;
          1: pct = 50;
          default: pct = 90;
        endcase
        queue_burst(len, pct);
        left -= len;
      end
    end

    while (pending_req.size() != 0 || expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errs == 0) begin
      $display("tb_free_list_slot_allocator: clean");
    end else begin
      $display("tb_free_list_slot_allocator: errors");
    end
    $finish;
  end

endmodule

@@ free_list_slot_allocator.f @@
+incdir+rtl
rtl/fsla_pkg.sv
rtl/fsla_ctrl.sv
rtl/fsla_datapath.sv
rtl/free_list_slot_allocator.sv
tb/sv/tb_free_list_slot_allocator.sv
